// ===== design/mlbs_pkg.sv =====
`timescale 1ns / 1ps
package mlbs_pkg;

	localparam int unsigned StateW   = 4;
	localparam int unsigned TcountW  = 16;
	localparam int unsigned BcountW  = 8;
	localparam int unsigned ApbDataW = 32;
	localparam int unsigned ApbAddrW = 3;

	// link states
	localparam logic [StateW-1:0] ST_IDLE      = 4'd0;
	localparam logic [StateW-1:0] ST_NET_OPEN  = 4'd8;
	localparam logic [StateW-1:0] ST_CONNECTED = 4'd9;
	localparam logic [StateW-1:0] ST_ERROR     = 4'd10;

	// event kinds carried on s_tuser
	localparam logic CMD_POLL  = 1'b0;
	localparam logic CMD_FORCE = 1'b1;

	// register indexes
	localparam logic REG_TIMEOUT_LIMIT  = 1'b0;
	localparam logic REG_BUSY_THRESHOLD = 1'b1;

	localparam logic [TcountW-1:0] TimeoutLimitRst  = 16'd100;
	localparam logic [BcountW-1:0] BusyThresholdRst = 8'd30;

	typedef struct packed {
		logic [TcountW-1:0] timeout_limit;
		logic [BcountW-1:0] busy_threshold;
	} cfg_t;

	typedef struct packed {
		logic [StateW-1:0]  link_state;
		logic [TcountW-1:0] tcount;
		logic [BcountW-1:0] bcount;
	} seq_t;

	function automatic logic counts_as_busy(input logic [StateW-1:0] s);
		return (s != ST_IDLE) && (s != ST_CONNECTED);
	endfunction

endpackage

// ===== design/mlbs_regs.sv =====
`timescale 1ns / 1ps
module mlbs_regs
	import mlbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready,
	output cfg_t                cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_limit  <= TimeoutLimitRst;
			cfg_q.busy_threshold <= BusyThresholdRst;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_TIMEOUT_LIMIT:  cfg_q.timeout_limit  <= pwdata[TcountW-1:0];
				REG_BUSY_THRESHOLD: cfg_q.busy_threshold <= pwdata[BcountW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_TIMEOUT_LIMIT:  prdata[TcountW-1:0] = cfg_q.timeout_limit;
			REG_BUSY_THRESHOLD: prdata[BcountW-1:0] = cfg_q.busy_threshold;
			default: ;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== design/mlbs_step.sv =====
`timescale 1ns / 1ps
module mlbs_step
	import mlbs_pkg::*;
(
	input  cfg_t cfg,
	input  seq_t cur,
	input  logic cmd,
	input  logic step_ok,
	output seq_t nxt,
	output logic busy_flag
);

	logic [StateW-1:0]  st_to;
	logic [TcountW-1:0] tc_to;

	always_comb begin
		// timeout supervision
		st_to = cur.link_state;
		tc_to = cur.tcount;
		if (counts_as_busy(cur.link_state)) begin
			if (cur.tcount != {TcountW{1'b1}})
				tc_to = cur.tcount + 1'b1;
		end else if (cur.link_state == ST_CONNECTED) begin
			tc_to = '0;
		end
		if (tc_to >= cfg.timeout_limit) begin
			st_to = ST_ERROR;
			tc_to = '0;
		end

		nxt = cur;
		if (cmd == CMD_FORCE) begin
			nxt.link_state = ST_NET_OPEN;
		end else begin
			nxt.tcount = tc_to;
			// sequence step; error and unused codes fall back to idle
			if (st_to <= ST_NET_OPEN) begin
				nxt.link_state = step_ok ? st_to + 1'b1 : st_to;
			end else if (st_to == ST_CONNECTED) begin
				nxt.link_state = step_ok ? ST_NET_OPEN : ST_CONNECTED;
			end else begin
				nxt.link_state = ST_IDLE;
			end
			if (counts_as_busy(nxt.link_state)) begin
				if (cur.bcount != {BcountW{1'b1}})
					nxt.bcount = cur.bcount + 1'b1;
			end else begin
				nxt.bcount = '0;
			end
		end
		busy_flag = (nxt.bcount >= cfg.busy_threshold);
	end

endmodule

// ===== design/modem_link_bringup_sequencer.sv =====
`timescale 1ns / 1ps
// A word accepted at a clock edge lands in the input register there and moves to the result
// register (m_*) at the next edge the result register is free.
// Throughput: one word per cycle while the result register drains (m_tready high); the state
// update is a single pass of compare/increment logic between the input and result registers.
// Reset (arst_n, async, active low): state idle, counters zero,
// timeout_limit 100, busy_threshold 30, both pipeline stages empty.
module modem_link_bringup_sequencer
	import mlbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// APB config
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready,
	// event stream in
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,  // [0] step_ok, [7:1] zero
	input  logic                s_tuser,  // [0] cmd (0 poll, 1 force net open)
	// result stream out
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata   // [3:0] link_state, [4] busy_flag, [7:5] zero
);

	cfg_t cfg;
	seq_t seq_q;
	seq_t seq_nxt;
	logic busy_nxt;

	logic v_s1;
	logic cmd_s1;
	logic ok_s1;

	logic             m_tvalid_q;
	logic [StateW-1:0] link_state_s2;
	logic             busy_flag_s2;

	logic adv;

	mlbs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mlbs_step u_step (
		.cfg       (cfg),
		.cur       (seq_q),
		.cmd       (cmd_s1),
		.step_ok   (ok_s1),
		.nxt       (seq_nxt),
		.busy_flag (busy_nxt)
	);

	// result register frees up when empty or being drained
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = !v_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= s_tuser;
			ok_s1  <= s_tdata[0];
		end
	end

	// sequencer state advances exactly when the word moves to the result reg
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= v_s1;
			if (v_s1)
				seq_q <= seq_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			link_state_s2 <= seq_nxt.link_state;
			busy_flag_s2  <= busy_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, busy_flag_s2, link_state_s2};

`ifndef SYNTHESIS
	// busy counter is always cleared on entry to idle or connected
	a_bcount_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q.link_state == ST_IDLE || seq_q.link_state == ST_CONNECTED)
		|-> seq_q.bcount == '0)
		else $error("busy count nonzero in idle/connected");

	// never leaves the defined state range
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q.link_state <= ST_ERROR)
		else $error("link state out of range");

	// a stalled input-stage word is held, not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(cmd_s1) && $stable(ok_s1)))
		else $error("input stage lost a word under stall");
`endif

endmodule

// ===== sim/modem_link_bringup_sequencer_test.sv =====
`timescale 1ns / 1ps
module modem_link_bringup_sequencer_test;
	import mlbs_pkg::*;

	localparam int unsigned PIPE_LAT    = 2;    // word in -> word out, through the input then the result register
	localparam int unsigned HOLD_LEN    = 80;   // long receiver back-pressure stretch
	localparam int unsigned QUIET_LIMIT = 5000; // cycles with no handshake on either side
	localparam int unsigned N_PHASES    = 6;
	localparam int unsigned PHASE_WORDS = 140;
	localparam int unsigned N_SCRIPT    = 25;

	// expected result word
	typedef struct packed {
		logic [StateW-1:0] link_state;
		logic              busy_flag;
	} link_out_t;

	// directed script: either an event word or a register write
	typedef enum logic [1:0] {ROW_EVENT, ROW_SET_LIMIT, ROW_SET_THRESH} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic              cmd;
		logic              ok;
		bit                typed;  // expected word given in the row itself
		logic [StateW-1:0] st;
		logic              busy;
		int unsigned       value;  // register value for the write rows
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;   // [0] step_ok, [7:1] zero
	logic                s_tuser;   // [0] cmd
	logic                m_tvalid;
	logic                m_tready;
	logic [7:0]          m_tdata;   // [3:0] link_state, [4] busy_flag, [7:5] zero

	// predictor state, mirrors the block after reset
	logic [StateW-1:0]  link_now     = ST_IDLE;
	logic [TcountW-1:0] timeout_cnt  = '0;
	logic [BcountW-1:0] busy_cnt     = '0;
	logic [TcountW-1:0] limit_reg    = TimeoutLimitRst;
	logic [BcountW-1:0] thresh_reg   = BusyThresholdRst;

	link_out_t   pending_links[$];
	int unsigned fail_count   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned tx_idle_pct  = 0;
	int unsigned rx_idle_pct  = 0;
	int unsigned hold_req     = 0;
	int unsigned hold_seen    = 0;
	int unsigned hold_left    = 0;

	script_row_t script [N_SCRIPT] = '{
		// reset values: idle, counters clear
		'{ROW_EVENT, CMD_POLL,  1'b0, 1'b1, ST_IDLE,     1'b0, 0},
		// force from idle jumps straight to net open
		'{ROW_EVENT, CMD_FORCE, 1'b0, 1'b1, ST_NET_OPEN, 1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},  // -> connected
		'{ROW_EVENT, CMD_POLL,  1'b0, 1'b0, ST_IDLE,     1'b0, 0},  // stay connected
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},  // link lost
		'{ROW_EVENT, CMD_FORCE, 1'b1, 1'b0, ST_IDLE,     1'b0, 0},  // step_ok ignored
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		// smallest legal limit: first busy poll times out, error falls through to idle
		'{ROW_SET_LIMIT,  CMD_POLL, 1'b0, 1'b0, ST_IDLE, 1'b0, 1},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b1, ST_IDLE,     1'b0, 0},
		// largest limit: walk the whole sequence idle .. connected
		'{ROW_SET_LIMIT,  CMD_POLL, 1'b0, 1'b0, ST_IDLE, 1'b0, 65535},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b0, ST_IDLE,     1'b0, 0},
		// zero threshold: flag always up; zero limit: every poll lands in idle
		'{ROW_SET_THRESH, CMD_POLL, 1'b0, 1'b0, ST_IDLE, 1'b0, 0},
		'{ROW_SET_LIMIT,  CMD_POLL, 1'b0, 1'b0, ST_IDLE, 1'b0, 0},
		'{ROW_EVENT, CMD_POLL,  1'b1, 1'b1, ST_IDLE,     1'b1, 0},
		'{ROW_EVENT, CMD_FORCE, 1'b0, 1'b1, ST_NET_OPEN, 1'b1, 0},
		'{ROW_EVENT, CMD_POLL,  1'b0, 1'b1, ST_IDLE,     1'b1, 0}
	};

	modem_link_bringup_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// Next link state for one event; updates the predictor state.
	// Order per poll: timeout supervision, sequence step, busy count.
	function automatic link_out_t advance_link(input logic cmd, input logic ok);
		link_out_t res;
		if (cmd == CMD_FORCE) begin
			link_now = ST_NET_OPEN;  // counters untouched
		end else begin
			if (link_now != ST_IDLE && link_now != ST_CONNECTED) begin
				if (timeout_cnt != '1)
					timeout_cnt = timeout_cnt + 1'b1;
			end else if (link_now == ST_CONNECTED) begin
				timeout_cnt = '0;
			end
			if (timeout_cnt >= limit_reg) begin
				link_now    = ST_ERROR;
				timeout_cnt = '0;
			end

			if (link_now <= ST_NET_OPEN) begin
				if (ok)
					link_now = link_now + 1'b1;
			end else if (link_now == ST_CONNECTED) begin
				if (ok)
					link_now = ST_NET_OPEN;  // link dropped
			end else begin
				link_now = ST_IDLE;          // error and unused codes
			end

			if (link_now != ST_IDLE && link_now != ST_CONNECTED) begin
				if (busy_cnt != '1)
					busy_cnt = busy_cnt + 1'b1;
			end else begin
				busy_cnt = '0;
			end
		end
		res.link_state = link_now;
		res.busy_flag  = (busy_cnt >= thresh_reg);
		return res;
	endfunction

	// Offer one event word; the expected result is queued at the handshake.
	task automatic push_event(input logic cmd, input logic ok, input bit typed,
			input link_out_t typed_out);
		link_out_t predicted;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, ok};
		do @(posedge clk); while (!s_tready);
		predicted = advance_link(cmd, ok);
		pending_links.push_back(typed ? typed_out : predicted);
	endtask

	// Register write while the pipe is empty: drain, let the last word clear, then APB write.
	task automatic set_reg(input logic idx, input int unsigned value);
		s_tvalid <= 1'b0;
		while (pending_links.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);  // write lands here, pready is tied high
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_TIMEOUT_LIMIT)
			limit_reg = value[TcountW-1:0];
		else
			thresh_reg = value[BcountW-1:0];
	endtask

	// Receiver: random idling, plus one long hold on request so the pipe
	// fills and s_tready drops while the sender keeps offering.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Result checker: in-order compare against the oldest expected word.
	always @(posedge clk) begin
		link_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_links.size() == 0) begin
				$error("unexpected result word: link_state %0d busy_flag %0d",
					m_tdata[3:0], m_tdata[4]);
				fail_count = fail_count + 1;
			end else begin
				want = pending_links.pop_front();
				if (m_tdata[3:0] !== want.link_state) begin
					$error("link_state: expected %0d, got %0d", want.link_state, m_tdata[3:0]);
					fail_count = fail_count + 1;
				end
				if (m_tdata[4] !== want.busy_flag) begin
					$error("busy_flag: expected %0d, got %0d", want.busy_flag, m_tdata[4]);
					fail_count = fail_count + 1;
				end
			end
		end
	end

	// Watchdog: too long without any handshake means the block hung.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned phase_limit [N_PHASES];
		int unsigned phase_thresh [N_PHASES];
		int unsigned burst;
		int unsigned pick;
		link_out_t   typed_out;

		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_POLL;
		m_tready = 1'b0;

		// register settings per random phase: reset values, both extremes,
		// two tight ones that make timeouts and the flag frequent, one random
		phase_limit  = '{100, 1, 65535, 20, 8, $urandom_range(1, 300)};
		phase_thresh = '{30, 0, 255, 10, 3, $urandom_range(0, 255)};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script, no idling
		foreach (script[i]) begin
			case (script[i].kind)
				ROW_SET_LIMIT:  set_reg(REG_TIMEOUT_LIMIT, script[i].value);
				ROW_SET_THRESH: set_reg(REG_BUSY_THRESHOLD, script[i].value);
				default: begin
					typed_out.link_state = script[i].st;
					typed_out.busy_flag  = script[i].busy;
					push_event(script[i].cmd, script[i].ok, script[i].typed, typed_out);
				end
			endcase
		end

		// random phases: mostly successful polls that walk the sequence,
		// runs of failed polls long enough to hit the timeout and busy
		// threshold, and the odd force word
		for (int ph = 0; ph < N_PHASES; ph++) begin
			set_reg(REG_TIMEOUT_LIMIT, phase_limit[ph]);
			set_reg(REG_BUSY_THRESHOLD, phase_thresh[ph]);
			case (ph / 2)
				0: begin
					tx_idle_pct = 25;
					rx_idle_pct <= 48;
				end
				1: begin
					tx_idle_pct = 48;
					rx_idle_pct <= 25;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			if (ph == 0)
				hold_req <= hold_req + 1;
			burst = 0;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				pick = $urandom_range(0, 99);
				if (burst != 0) begin
					burst--;
					push_event(CMD_POLL, 1'b0, 1'b0, '0);
				end else if (pick < 5) begin
					push_event(CMD_FORCE, 1'($urandom_range(0, 1)), 1'b0, '0);
				end else if (pick < 9) begin
					burst = $urandom_range(10, 300);
					push_event(CMD_POLL, 1'b0, 1'b0, '0);
				end else begin
					push_event(CMD_POLL, ($urandom_range(0, 99) < 80), 1'b0, '0);
				end
			end
		end

		s_tvalid <= 1'b0;
		while (pending_links.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 6) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/mlbs_pkg.sv
design/mlbs_regs.sv
design/mlbs_step.sv
design/modem_link_bringup_sequencer.sv
sim/modem_link_bringup_sequencer_test.sv
